// ===== sv/mhte_pkg.sv =====
// Shared types, widths, constants and helper functions for the heater thermostat encoder.
package mhte_pkg;

    // Number of heater channels the select button cycles through (2 to 8)
    localparam int CHANNELS = 4;
    localparam int CH_W     = (CHANNELS > 4) ? 3 : 2;

    // Field widths
    localparam int RAW_W    = 12;
    localparam int TEMP_W   = 13;
    localparam int SP_W     = 10;
    localparam int CNT_W    = 16;
    localparam int DB_W     = 10;
    localparam int OFS_W    = 10;
    localparam int NUM_TEMP = 4;
    localparam int NUM_SP   = 3;

    // Reset values and limits
    localparam logic [SP_W-1:0]  SP_RESET       = 10'd350;
    localparam logic [SP_W-1:0]  SP_MAX         = 10'd1023;
    localparam logic [CNT_W-1:0] CNT_MAX        = 16'hFFFF;
    localparam logic [CNT_W-1:0] INTERVAL_RESET = 16'd500;
    localparam logic [DB_W-1:0]  DEBOUNCE_RESET = 10'd50;
    localparam logic [OFS_W-1:0] OFFSET_RESET   = 10'd400;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OFFSET    = 2'd2;
    localparam int CFG_DATA_W = 16;

    // Quadrature step direction
    typedef enum logic [1:0] {
        ENC_HOLD = 2'd0,
        ENC_UP   = 2'd1,
        ENC_DOWN = 2'd2
    } enc_dir_t;

    typedef logic [NUM_SP-1:0][SP_W-1:0]     sp_arr_t;
    typedef logic [NUM_TEMP-1:0][TEMP_W-1:0] temp_arr_t;

    // One registered input request
    typedef struct packed {
        logic                           enc_a;
        logic                           enc_b;
        logic                           button_low;
        logic                           ms_tick;
        logic [NUM_TEMP-1:0][RAW_W-1:0] temp;
        logic [NUM_TEMP-1:0]            fault_mask;
    } in_item_t;

    // Transition table: previous pins in the high bits, new pins in the low bits
    function automatic enc_dir_t enc_decode(input logic [3:0] code);
        enc_dir_t dir;
        unique case (code)
            4'd13, 4'd4, 4'd2, 4'd11: dir = ENC_UP;
            4'd14, 4'd7, 4'd1, 4'd8:  dir = ENC_DOWN;
            default:                  dir = ENC_HOLD;
        endcase
        return dir;
    endfunction

    // Channel three borrows setpoint one; channels past three have none
    function automatic logic [SP_W-1:0] setpoint_of(input logic [CH_W-1:0] ch,
                                                    input sp_arr_t sp);
        logic [SP_W-1:0] v;
        if (ch == CH_W'(0))      v = sp[0];
        else if (ch == CH_W'(1)) v = sp[1];
        else if (ch == CH_W'(2)) v = sp[2];
        else if (ch == CH_W'(3)) v = sp[1];
        else                     v = '0;
        return v;
    endfunction

endpackage

// ===== sv/mhte_in_reg.sv =====
// Input register stage: captures one request and holds it until the state stage takes it.
module mhte_in_reg
    import mhte_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     take,
    output logic     p_valid,
    output in_item_t p_item
);

    logic     valid_reg;
    in_item_t item_reg;

    // Room when empty or when the held request moves on this cycle
    assign s_ready = !valid_reg || take;
    assign p_valid = valid_reg;
    assign p_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== sv/mhte_thermo.sv =====
// Thermostat state: encoder setpoints, button select, sample timing, heaters, result register.
module mhte_thermo
    import mhte_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  p_valid,
    input  in_item_t              p_item,
    output logic                  take,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [NUM_TEMP-1:0]   heater_mask,
    output logic [1:0]            selected_channel,
    output logic [SP_W-1:0]       shown_setpoint,
    output logic [TEMP_W-1:0]     shown_temperature
);

    // Configuration
    logic [CNT_W-1:0] interval_reg;
    logic [DB_W-1:0]  debounce_reg;
    logic [OFS_W-1:0] offset_reg;

    // Controller state
    logic [1:0]          pins_reg;
    sp_arr_t             sp_reg,  sp_next;
    logic [CH_W-1:0]     ch_reg,  ch_next;
    logic [CNT_W-1:0]    press_reg, press_next;
    logic                await_reg, await_next;
    logic [CNT_W-1:0]    sample_reg, sample_next;
    temp_arr_t           lat_reg, lat_next;
    logic [NUM_TEMP-1:0] heat_reg, heat_next;

    // Result register
    logic                m_valid_reg;
    logic [NUM_TEMP-1:0] heater_reg;
    logic [1:0]          sel_reg;
    logic [SP_W-1:0]     shown_sp_reg;
    logic [TEMP_W-1:0]   shown_t_reg;

    logic [1:0]       pins;
    enc_dir_t         dir;
    logic [CNT_W-1:0] press_cnt, sample_cnt;
    logic             press_hit, sample_hit;
    logic [SP_W-1:0]  sel_sp;
    logic [SP_W-1:0]  cur_sp;

    assign take = p_valid && (!m_valid_reg || m_ready);

    assign pins   = {p_item.enc_a, p_item.enc_b};
    assign dir    = enc_decode({pins_reg, pins});
    assign cur_sp = (ch_reg < CH_W'(NUM_SP)) ? sp_reg[ch_reg[1:0]] : '0;

    // Encoder, millisecond counters, button, then sample instant
    always_comb begin
        sp_next = sp_reg;
        if (ch_reg < CH_W'(NUM_SP)) begin
            unique case (dir)
                ENC_UP:   if (cur_sp != SP_MAX) sp_next[ch_reg[1:0]] = cur_sp + 1'b1;
                ENC_DOWN: if (cur_sp != '0)     sp_next[ch_reg[1:0]] = cur_sp - 1'b1;
                default:  ;
            endcase
        end

        press_cnt  = press_reg;
        sample_cnt = sample_reg;
        if (p_item.ms_tick) begin
            if (press_reg != CNT_MAX)  press_cnt  = press_reg + 1'b1;
            if (sample_reg != CNT_MAX) sample_cnt = sample_reg + 1'b1;
        end

        press_hit  = p_item.button_low && !await_reg &&
                     (press_cnt > CNT_W'(debounce_reg));
        press_next = press_hit ? '0 : press_cnt;
        if (!p_item.button_low) begin
            await_next = 1'b0;
        end else begin
            await_next = await_reg || press_hit;
        end
        ch_next = ch_reg;
        if (press_hit) begin
            ch_next = (ch_reg == CH_W'(CHANNELS - 1)) ? '0 : ch_reg + 1'b1;
        end

        sample_hit  = (sample_cnt >= interval_reg);
        sample_next = sample_hit ? '0 : sample_cnt;
        lat_next    = lat_reg;
        heat_next   = heat_reg;
        if (sample_hit) begin
            for (int i = 0; i < NUM_TEMP; i++) begin
                if (p_item.fault_mask[i]) begin
                    lat_next[i] = '0;
                end else if (i == 0) begin
                    lat_next[i] = TEMP_W'(p_item.temp[i]) + TEMP_W'(offset_reg);
                end else begin
                    lat_next[i] = TEMP_W'(p_item.temp[i]);
                end
                heat_next[i] = lat_next[i] <
                    TEMP_W'({setpoint_of(CH_W'(i), sp_next), 2'b00});
            end
        end

        sel_sp = setpoint_of(ch_next, sp_next);
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
            debounce_reg <= DEBOUNCE_RESET;
            offset_reg   <= OFFSET_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SAMPLE_INTERVAL: interval_reg <= cfg_wdata;
                CFG_DEBOUNCE:        debounce_reg <= cfg_wdata[DB_W-1:0];
                CFG_FIRST_OFFSET:    offset_reg   <= cfg_wdata[OFS_W-1:0];
                default:             ;
            endcase
        end
    end

    // State update and result capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pins_reg    <= '0;
            sp_reg      <= {NUM_SP{SP_RESET}};
            ch_reg      <= '0;
            press_reg   <= '0;
            await_reg   <= 1'b0;
            sample_reg  <= '0;
            lat_reg     <= '0;
            heat_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                pins_reg    <= pins;
                sp_reg      <= sp_next;
                ch_reg      <= ch_next;
                press_reg   <= press_next;
                await_reg   <= await_next;
                sample_reg  <= sample_next;
                lat_reg     <= lat_next;
                heat_reg    <= heat_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (take) begin
            heater_reg   <= heat_next;
            sel_reg      <= ch_next[1:0];
            shown_sp_reg <= sel_sp;
            shown_t_reg  <= (int'(ch_next) < NUM_TEMP) ? lat_next[ch_next[1:0]] : '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign heater_mask       = heater_reg;
    assign selected_channel  = sel_reg;
    assign shown_setpoint    = shown_sp_reg;
    assign shown_temperature = shown_t_reg;

    // A request only moves when the result slot is free or draining
    a_take_room: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> (!m_valid_reg || m_ready))
        else $error("request taken while result register blocked");

    // An accepted press restarts the debounce count and arms release wait
    a_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && press_hit) |=> (await_reg && press_reg == '0))
        else $error("press did not arm release wait");

    // A sample instant restarts the sample interval
    a_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && sample_hit) |=> (sample_reg == '0))
        else $error("sample counter not cleared");

    // Without a taken request the setpoints and channel hold
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !take |=> ($stable(sp_reg) && $stable(ch_reg)))
        else $error("state changed without a request");

    // Channel stays in range
    a_ch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(ch_reg) < CHANNELS)
        else $error("channel out of range");

endmodule

// ===== sv/multi_heater_thermostat_encoder_core.sv =====
// Path: an accepted request sits in the input register, then one registered pass moves it
//   into the state/result register, which drives result valid.
// Throughput: one request per cycle while m_ready stays high; each update is one registered pass.
// Input ready follows the result register: a request moves on whenever the result is free or taken.
// Reset (aresetn low, synchronous): setpoints 350, channel 0, counters 0, latched readings 0,
//   heaters off, configuration back to 500 ms interval, 50 ms debounce, 400 offset.
module multi_heater_thermostat_encoder_core
    import mhte_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_enc_a,
    input  logic                  s_enc_b,
    input  logic                  s_button_low,
    input  logic                  s_ms_tick,
    input  logic [RAW_W-1:0]      s_temp_ch0,
    input  logic [RAW_W-1:0]      s_temp_ch1,
    input  logic [RAW_W-1:0]      s_temp_ch2,
    input  logic [RAW_W-1:0]      s_temp_ch3,
    input  logic [NUM_TEMP-1:0]   s_fault_mask,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [NUM_TEMP-1:0]   m_heater_mask,
    output logic [1:0]            m_selected_channel,
    output logic [SP_W-1:0]       m_shown_setpoint,
    output logic [TEMP_W-1:0]     m_shown_temperature
);

    in_item_t s_item, p_item;
    logic     p_valid, take;

    // Pack the request fields
    always_comb begin
        s_item            = '0;
        s_item.enc_a      = s_enc_a;
        s_item.enc_b      = s_enc_b;
        s_item.button_low = s_button_low;
        s_item.ms_tick    = s_ms_tick;
        s_item.temp[0]    = s_temp_ch0;
        s_item.temp[1]    = s_temp_ch1;
        s_item.temp[2]    = s_temp_ch2;
        s_item.temp[3]    = s_temp_ch3;
        s_item.fault_mask = s_fault_mask;
    end

    mhte_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .take    (take),
        .p_valid (p_valid),
        .p_item  (p_item)
    );

    mhte_thermo u_thermo (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .p_valid           (p_valid),
        .p_item            (p_item),
        .take              (take),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .heater_mask       (m_heater_mask),
        .selected_channel  (m_selected_channel),
        .shown_setpoint    (m_shown_setpoint),
        .shown_temperature (m_shown_temperature)
    );

endmodule

// ===== test/multi_heater_thermostat_encoder_core_test.sv =====
// Self-checking testbench for the multi-heater thermostat core: predicts and checks every report.
`timescale 1ns / 1ps

module multi_heater_thermostat_encoder_core_test;
    import mhte_pkg::*;

    localparam int     CLK_HALF      = 5;
    localparam int     RESET_CYCLES  = 7;
    localparam int     SETTLE_CYCLES = 6;
    localparam longint CYCLE_LIMIT   = 1_000_000;
    localparam int     PHASE_ITEMS   = 40;
    localparam int     LONG_ITEMS    = 30;
    localparam int     SHARED_SP     = 1;      // channel three follows setpoint one
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One status report as the block presents it
    typedef struct packed {
        logic [NUM_TEMP-1:0] heater_mask;
        logic [1:0]          selected_channel;
        logic [SP_W-1:0]     shown_setpoint;
        logic [TEMP_W-1:0]   shown_temperature;
    } status_t;

    // Block ports
    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic                  s_enc_a      = 1'b0;
    logic                  s_enc_b      = 1'b0;
    logic                  s_button_low = 1'b0;
    logic                  s_ms_tick    = 1'b0;
    logic [RAW_W-1:0]      s_temp_ch0   = '0;
    logic [RAW_W-1:0]      s_temp_ch1   = '0;
    logic [RAW_W-1:0]      s_temp_ch2   = '0;
    logic [RAW_W-1:0]      s_temp_ch3   = '0;
    logic [NUM_TEMP-1:0]   s_fault_mask = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [NUM_TEMP-1:0]   m_heater_mask;
    logic [1:0]            m_selected_channel;
    logic [SP_W-1:0]       m_shown_setpoint;
    logic [TEMP_W-1:0]     m_shown_temperature;

    // Predicted thermostat state and register settings
    logic [1:0]       pred_pins;
    sp_arr_t          pred_setpoint;
    logic [CH_W-1:0]  pred_channel;
    logic [CNT_W-1:0] pred_since_press;
    logic             pred_awaiting;
    logic [CNT_W-1:0] pred_since_sample;
    temp_arr_t        pred_latched;
    logic [NUM_TEMP-1:0] pred_heaters;
    logic [CNT_W-1:0] set_interval;
    logic [DB_W-1:0]  set_debounce;
    logic [OFS_W-1:0] set_offset;

    status_t expected_status_q[$];
    status_t want;

    // Stimulus shaping
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  enc_trend      = 1;
    bit  steer_enc      = 1'b0;
    int  button_left    = 0;
    bit  button_level   = 1'b0;

    // Bookkeeping
    int     errors          = 0;
    int     requests_sent   = 0;
    int     reports_checked = 0;
    int     reg_writes      = 0;
    int     samples_taken   = 0;
    int     presses_taken   = 0;
    longint cycle_count     = 0;

    multi_heater_thermostat_encoder_core u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_enc_a             (s_enc_a),
        .s_enc_b             (s_enc_b),
        .s_button_low        (s_button_low),
        .s_ms_tick           (s_ms_tick),
        .s_temp_ch0          (s_temp_ch0),
        .s_temp_ch1          (s_temp_ch1),
        .s_temp_ch2          (s_temp_ch2),
        .s_temp_ch3          (s_temp_ch3),
        .s_fault_mask        (s_fault_mask),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_heater_mask       (m_heater_mask),
        .m_selected_channel  (m_selected_channel),
        .m_shown_setpoint    (m_shown_setpoint),
        .m_shown_temperature (m_shown_temperature)
    );

    always #CLK_HALF aclk = ~aclk;

    // ---------------------------------------------------------------- prediction

    function automatic void reset_model();
        pred_pins         = '0;
        pred_setpoint     = {NUM_SP{SP_RESET}};
        pred_channel      = '0;
        pred_since_press  = '0;
        pred_awaiting     = 1'b0;
        pred_since_sample = '0;
        pred_latched      = '0;
        pred_heaters      = '0;
        set_interval      = INTERVAL_RESET;
        set_debounce      = DEBOUNCE_RESET;
        set_offset        = OFFSET_RESET;
    endfunction

    function automatic logic [SP_W-1:0] setpoint_for(input int ch);
        if (ch < NUM_SP) return pred_setpoint[ch];
        if (ch == NUM_SP) return pred_setpoint[SHARED_SP];
        return '0;
    endfunction

    // Position along the quadrature cycle 00 -> 10 -> 11 -> 01 (pins are {a, b})
    function automatic logic [1:0] quad_phase(input logic [1:0] pins);
        return {pins[0], pins[1] ^ pins[0]};
    endfunction

    function automatic logic [1:0] pins_at_phase(input logic [1:0] ph);
        return {ph[1] ^ ph[0], ph[1]};
    endfunction

    function automatic enc_dir_t quad_direction(input logic [1:0] old_pins,
                                                input logic [1:0] new_pins);
        logic [1:0] delta;
        delta = quad_phase(new_pins) - quad_phase(old_pins);
        if (delta == 2'd1) return ENC_UP;
        if (delta == 2'(-1)) return ENC_DOWN;
        return ENC_HOLD;    // no movement, or a two-quarter jump
    endfunction

    // Apply one request to the predicted state and return the report it causes
    function automatic status_t advance_thermostat(input in_item_t req);
        logic [1:0] pins;
        enc_dir_t   dir;
        int         t;
        int         i;
        status_t    st;

        // encoder moves the setpoint of an adjustable channel only
        pins = {req.enc_a, req.enc_b};
        dir  = quad_direction(pred_pins, pins);
        if (pred_channel < NUM_SP) begin
            if (dir == ENC_UP && pred_setpoint[pred_channel] != SP_MAX)
                pred_setpoint[pred_channel] = pred_setpoint[pred_channel] + 1'b1;
            else if (dir == ENC_DOWN && pred_setpoint[pred_channel] != '0)
                pred_setpoint[pred_channel] = pred_setpoint[pred_channel] - 1'b1;
        end
        pred_pins = pins;

        // millisecond counters saturate
        if (req.ms_tick) begin
            if (pred_since_press != CNT_MAX) pred_since_press = pred_since_press + 1'b1;
            if (pred_since_sample != CNT_MAX) pred_since_sample = pred_since_sample + 1'b1;
        end

        // button: debounced press, then wait for release
        if (!req.button_low) begin
            pred_awaiting = 1'b0;
        end else if (!pred_awaiting && pred_since_press > CNT_W'(set_debounce)) begin
            pred_since_press = '0;
            pred_channel     = CH_W'((int'(pred_channel) + 1) % CHANNELS);
            pred_awaiting    = 1'b1;
            presses_taken++;
        end

        // sample instant: latch readings and decide heaters
        if (pred_since_sample >= set_interval) begin
            pred_since_sample = '0;
            pred_heaters      = '0;
            samples_taken++;
            for (i = 0; i < NUM_TEMP; i++) begin
                if (req.fault_mask[i]) t = 0;
                else t = int'(req.temp[i]) + ((i == 0) ? int'(set_offset) : 0);
                pred_latched[i] = TEMP_W'(t);
                if (t < 4 * int'(setpoint_for(i))) pred_heaters[i] = 1'b1;
            end
        end

        st.heater_mask       = pred_heaters;
        st.selected_channel  = pred_channel[1:0];
        st.shown_setpoint    = setpoint_for(int'(pred_channel));
        st.shown_temperature = (pred_channel < NUM_TEMP) ? pred_latched[pred_channel] : '0;
        return st;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // Extremes, readings near the heater threshold, and half the time any value
    function automatic logic [RAW_W-1:0] random_reading(input int ch);
        int v;
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3: begin
                v = 4 * int'(setpoint_for(ch)) + int'($urandom_range(6)) - 3;
                if (v < 0) v = 0;
                if (v > (1 << RAW_W) - 1) v = (1 << RAW_W) - 1;
                return RAW_W'(v);
            end
            default: return RAW_W'($urandom_range((1 << RAW_W) - 1));
        endcase
    endfunction

    function automatic in_item_t make_request(input logic [1:0] pins, input bit btn,
                                              input bit tick,
                                              input logic [RAW_W-1:0] t0, t1, t2, t3,
                                              input logic [NUM_TEMP-1:0] faults);
        in_item_t req;
        req.enc_a      = pins[1];
        req.enc_b      = pins[0];
        req.button_low = btn;
        req.ms_tick    = tick;
        req.temp[0]    = t0;
        req.temp[1]    = t1;
        req.temp[2]    = t2;
        req.temp[3]    = t3;
        req.fault_mask = faults;
        return req;
    endfunction

    function automatic in_item_t pin_request(input logic [1:0] pins, input bit btn,
                                             input bit tick);
        return make_request(pins, btn, tick, random_reading(0), random_reading(1),
                            random_reading(2), random_reading(3), '0);
    endfunction

    // Well-formed encoder walks with occasional reversals and bad jumps, button in runs
    function automatic in_item_t random_request(input int tick_pct);
        logic [1:0] ph;
        int         roll;
        int         i;
        in_item_t   req;

        ph   = quad_phase(pred_pins);
        roll = $urandom_range(99);
        if (!steer_enc && $urandom_range(99) < 3) enc_trend = -enc_trend;
        if (steer_enc || roll < 70) ph = ph + 2'(enc_trend);
        else if (roll < 80) ph = ph - 2'(enc_trend);
        else if (roll >= 88) ph = 2'($urandom_range(3));
        {req.enc_a, req.enc_b} = pins_at_phase(ph);

        if (button_left == 0) begin
            button_level = !button_level;
            button_left  = button_level ? $urandom_range(1, 4) : $urandom_range(1, 8);
        end
        button_left--;
        req.button_low = button_level;
        req.ms_tick    = ($urandom_range(99) < tick_pct);
        for (i = 0; i < NUM_TEMP; i++) req.temp[i] = random_reading(i);
        req.fault_mask = ($urandom_range(99) < 70) ? '0
                                                   : NUM_TEMP'($urandom_range((1 << NUM_TEMP) - 1));
        return req;
    endfunction

    // ---------------------------------------------------------------- drivers

    // Offer one request, with random sender gaps, and predict it on acceptance
    task automatic send_request(input in_item_t req);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_enc_a      <= req.enc_a;
        s_enc_b      <= req.enc_b;
        s_button_low <= req.button_low;
        s_ms_tick    <= req.ms_tick;
        s_temp_ch0   <= req.temp[0];
        s_temp_ch1   <= req.temp[1];
        s_temp_ch2   <= req.temp[2];
        s_temp_ch3   <= req.temp[3];
        s_fault_mask <= req.fault_mask;
        do @(posedge aclk); while (!s_ready);
        expected_status_q.push_back(advance_thermostat(req));
        requests_sent++;
    endtask

    // Stop sending and let every pending report come back
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_SAMPLE_INTERVAL: set_interval = data;
            CFG_DEBOUNCE:        set_debounce = data[DB_W-1:0];
            CFG_FIRST_OFFSET:    set_offset   = data[OFS_W-1:0];
            default:             ;
        endcase
        reg_writes++;
    endtask

    // Rewrite all registers with the block idle
    task automatic configure(input logic [CNT_W-1:0] interval, input logic [DB_W-1:0] debounce,
                             input logic [OFS_W-1:0] offset, input bit poke_unused);
        wait_for_results();
        write_register(CFG_SAMPLE_INTERVAL, interval);
        write_register(CFG_DEBOUNCE, CFG_DATA_W'(debounce));
        write_register(CFG_FIRST_OFFSET, CFG_DATA_W'(offset));
        if (poke_unused) write_register(CFG_UNUSED, '1);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_steered(input int count, input int trend);
        in_item_t req;
        steer_enc = 1'b1;
        enc_trend = trend;
        repeat (count) begin
            req            = random_request(50);
            req.button_low = 1'b0;
            send_request(req);
        end
        steer_enc = 1'b0;
    endtask

    // Result side stalls at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_status_q.size() == 0) begin
                errors++;
                $error("status report with no request pending");
            end else begin
                want = expected_status_q.pop_front();
                check_field("heater_mask", 16'(want.heater_mask), 16'(m_heater_mask));
                check_field("selected_channel", 16'(want.selected_channel),
                            16'(m_selected_channel));
                check_field("shown_setpoint", 16'(want.shown_setpoint), 16'(m_shown_setpoint));
                check_field("shown_temperature", 16'(want.shown_temperature),
                            16'(m_shown_temperature));
                reports_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, expected_status_q.size());
            $display("** multi_heater_thermostat_encoder_core: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // Reset values: nothing latched, heaters off, press blocked by debounce
    task automatic test_reset_defaults();
        send_request(pin_request(2'b00, 1'b1, 1'b1));
        send_request(pin_request(2'b10, 1'b0, 1'b1));
        send_request(pin_request(2'b00, 1'b0, 1'b0));
        send_request(pin_request(2'b00, 1'b1, 1'b0));
    endtask

    // Field extremes, faults, every encoder transition kind and the button rules
    task automatic test_extreme_fields();
        logic [1:0] enc_walk [10] = '{2'b10, 2'b11, 2'b01, 2'b00,
                                      2'b01, 2'b11, 2'b10, 2'b00,
                                      2'b11, 2'b00};
        int i;

        configure(16'd0, 10'd0, 10'd1023, 1'b0);
        // full scale (channel zero peaks with the offset), zero, then full scale with every channel faulted
        send_request(make_request(2'b00, 1'b0, 1'b1, '1, '1, '1, '1, '0));
        send_request(make_request(2'b00, 1'b0, 1'b1, '0, '0, '0, '0, '0));
        send_request(make_request(2'b00, 1'b0, 1'b1, '1, '1, '1, '1, '1));
        // one open thermocouple at a time, channels one to three read around the threshold
        for (i = 0; i < NUM_TEMP; i++)
            send_request(make_request(2'b00, 1'b0, 1'b1, 12'd999, 12'd1399, 12'd1400,
                                      12'd1401, NUM_TEMP'(1 << i)));
        // a full turn up, a full turn down, then two-quarter jumps
        for (i = 0; i < 10; i++) send_request(pin_request(enc_walk[i], 1'b0, 1'b1));

        // press, then a press too soon after it is ignored
        send_request(pin_request(pred_pins, 1'b1, 1'b1));
        send_request(pin_request(pred_pins, 1'b0, 1'b0));
        send_request(pin_request(pred_pins, 1'b1, 1'b0));
        send_request(pin_request(pred_pins, 1'b1, 1'b1));
        // held button does not advance again
        send_request(pin_request(pred_pins, 1'b1, 1'b1));
        send_request(pin_request(pred_pins, 1'b0, 1'b1));
        // channel three: borrowed setpoint, encoder ignored
        send_request(pin_request(pred_pins, 1'b1, 1'b1));
        send_request(pin_request(pins_at_phase(quad_phase(pred_pins) + 2'd1), 1'b1, 1'b1));
        send_request(pin_request(pred_pins, 1'b0, 1'b1));
        // wrap back to channel zero
        send_request(pin_request(pred_pins, 1'b1, 1'b1));
        send_request(pin_request(pred_pins, 1'b0, 1'b1));
    endtask

    // Drive one setpoint into the top rail and the next one into the bottom rail
    task automatic test_setpoint_rails();
        configure(16'd3, 10'd0, OFS_W'($urandom_range(1023)), 1'b0);
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        while (pred_channel >= NUM_SP) begin
            send_request(pin_request(pred_pins, 1'b0, 1'b1));
            send_request(pin_request(pred_pins, 1'b1, 1'b1));
        end
        send_steered(690, 1);
        // step to the next channel, skipping the one without a setpoint
        send_request(pin_request(pred_pins, 1'b1, 1'b1));
        send_request(pin_request(pred_pins, 1'b0, 1'b1));
        while (pred_channel >= NUM_SP) begin
            send_request(pin_request(pred_pins, 1'b1, 1'b1));
            send_request(pin_request(pred_pins, 1'b0, 1'b1));
        end
        send_steered(365, -1);
        send_steered(10, 1);
    endtask

    // Longest interval and debounce: no sample instant and no press in a short run
    task automatic test_longest_interval();
        configure(CNT_MAX, 10'd1023, 10'd0, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (LONG_ITEMS) send_request(random_request(100));
    endtask

    // Random traffic under each idling pattern and several register settings
    task automatic test_random_traffic();
        int send_pct [4] = '{0, 68, 0, 20};
        int recv_pct [4] = '{0, 0, 68, 20};
        int ph;
        int n;

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: configure(16'd1, 10'd0, 10'd0, 1'b0);
                1: configure(16'd0, 10'd1, 10'd1023, 1'b0);
                2: configure(CNT_W'($urandom_range(2, 9)), DB_W'($urandom_range(4)),
                             OFS_W'($urandom_range(1023)), 1'b1);
                default: configure(CNT_W'($urandom_range(1, 4)), DB_W'($urandom_range(2, 3)),
                                   OFS_W'($urandom_range(1023)), 1'b0);
            endcase
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // hold off halfway until the block has answered everything
                if (n == PHASE_ITEMS / 2) wait_for_results();
                send_request(random_request(50));
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        reset_model();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_extreme_fields();
        test_setpoint_rails();
        test_longest_interval();
        test_random_traffic();
        wait_for_results();

        $display("Sent %0d requests with %0d register writes; checked %0d reports.",
                 requests_sent, reg_writes, reports_checked);
        $display("Predicted %0d sample instants and %0d channel presses.",
                 samples_taken, presses_taken);
        if (errors == 0)
            $display("** multi_heater_thermostat_encoder_core: PASSED **");
        else
            $display("** multi_heater_thermostat_encoder_core: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mhte_pkg.sv
sv/mhte_in_reg.sv
sv/mhte_thermo.sv
sv/multi_heater_thermostat_encoder_core.sv
test/multi_heater_thermostat_encoder_core_test.sv
